// File: hw/rtl/udpchk_pkg.sv
package udpchk_pkg;

    localparam int PORT_SLOTS = 4;
    localparam int SLOT_REGS  = 4;
    localparam int SLOT_W     = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int ADDR_SUM_W = 19;

    localparam logic [2:0] VERDICT_ACCEPT     = 3'd0;
    localparam logic [2:0] VERDICT_SHORT      = 3'd1;
    localparam logic [2:0] VERDICT_BAD_LEN    = 3'd2;
    localparam logic [2:0] VERDICT_BAD_CKSUM  = 3'd3;
    localparam logic [2:0] VERDICT_NO_HANDLER = 3'd4;

    localparam logic [15:0] MIN_UDP_LEN = 16'd8;
    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
    localparam logic [15:0] UDP_PROTO   = 16'h0011;
    localparam logic [15:0] CKSUM_ONES  = 16'hFFFF;

    typedef struct packed {
        logic [15:0]           byte_len;
        logic [15:0]           sport;
        logic [15:0]           dst_port;
        logic [15:0]           hdr_len;
        logic                  cks_nz;
        logic [7:0]            held;
        logic [31:0]           sum;
        logic [ADDR_SUM_W-1:0] addr_sum;
    } t_fin;

    // even index writes the high half, odd index the low half
    function automatic logic [15:0] set_half(input logic [15:0] word, input logic odd,
                                             input logic [7:0] b);
        logic [15:0] res;
        if (odd) begin
            res = {word[15:8], b};
        end else begin
            res = {b, word[7:0]};
        end
        return res;
    endfunction

endpackage

// File: hw/rtl/udpchk_accum.sv
module udpchk_accum import udpchk_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_xfer,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic        i_last_byte,
    input  logic [31:0] i_source_addr,
    input  logic [31:0] i_dest_addr,
    input  logic        i_fin_take,
    output logic        o_fin_valid,
    output t_fin        o_fin
);

    logic [15:0]           r_count, n_count;
    logic [31:0]           r_sum, n_sum;
    logic [7:0]            r_held, n_held;
    logic [15:0]           r_src, n_src;
    logic [15:0]           r_dst, n_dst;
    logic [15:0]           r_len, n_len;
    logic                  r_nz, n_nz;
    logic [ADDR_SUM_W-1:0] r_addr_sum, n_addr_sum;
    logic                  r_fin_valid;
    t_fin                  r_fin;

    logic [15:0] base_count, base_src, base_dst, base_len;
    logic [31:0] base_sum;
    logic [7:0]  base_held;
    logic        base_nz;
    logic        sum_on;

    always_comb begin
        base_count = i_first_byte ? 16'd0 : r_count;
        base_sum   = i_first_byte ? 32'd0 : r_sum;
        base_held  = i_first_byte ? 8'd0  : r_held;
        base_src   = i_first_byte ? 16'd0 : r_src;
        base_dst   = i_first_byte ? 16'd0 : r_dst;
        base_len   = i_first_byte ? 16'd0 : r_len;
        base_nz    = i_first_byte ? 1'b0  : r_nz;

        n_src = base_src;
        n_dst = base_dst;
        n_len = base_len;
        n_nz  = base_nz;
        if (base_count < 16'd2) begin
            n_src = set_half(base_src, base_count[0], i_data_byte);
        end else if (base_count < 16'd4) begin
            n_dst = set_half(base_dst, base_count[0], i_data_byte);
        end else if (base_count < 16'd6) begin
            n_len = set_half(base_len, base_count[0], i_data_byte);
        end else if (base_count < MIN_UDP_LEN && i_data_byte != 8'd0) begin
            n_nz = 1'b1;
        end

        sum_on = (base_count != COUNT_MAX) && (base_count < 16'd6 || base_count < n_len);
        n_held = (sum_on && !base_count[0]) ? i_data_byte : base_held;
        n_sum  = (sum_on && base_count[0]) ? base_sum + {16'd0, base_held, i_data_byte}
                                           : base_sum;
        n_count = (base_count == COUNT_MAX) ? COUNT_MAX : base_count + 16'd1;

        n_addr_sum = r_addr_sum;
        if (i_first_byte) begin
            n_addr_sum = ADDR_SUM_W'(i_source_addr[31:16]) + ADDR_SUM_W'(i_source_addr[15:0])
                       + ADDR_SUM_W'(i_dest_addr[31:16]) + ADDR_SUM_W'(i_dest_addr[15:0])
                       + ADDR_SUM_W'(UDP_PROTO);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_sum       <= '0;
            r_held      <= '0;
            r_src       <= '0;
            r_dst       <= '0;
            r_len       <= '0;
            r_nz        <= 1'b0;
            r_addr_sum  <= ADDR_SUM_W'(UDP_PROTO);
            r_fin_valid <= 1'b0;
        end else begin
            if (i_xfer) begin
                r_addr_sum <= n_addr_sum;
                if (i_last_byte) begin
                    r_count <= '0;
                    r_sum   <= '0;
                    r_held  <= '0;
                    r_src   <= '0;
                    r_dst   <= '0;
                    r_len   <= '0;
                    r_nz    <= 1'b0;
                end else begin
                    r_count <= n_count;
                    r_sum   <= n_sum;
                    r_held  <= n_held;
                    r_src   <= n_src;
                    r_dst   <= n_dst;
                    r_len   <= n_len;
                    r_nz    <= n_nz;
                end
            end
            if (i_xfer && i_last_byte) begin
                r_fin_valid <= 1'b1;
            end else if (i_fin_take) begin
                r_fin_valid <= 1'b0;
            end
        end
    end

    // datagram snapshot taken at the last byte
    always_ff @(posedge i_clk) begin
        if (i_xfer && i_last_byte) begin
            r_fin.byte_len <= n_count;
            r_fin.sport    <= n_src;
            r_fin.dst_port <= n_dst;
            r_fin.hdr_len  <= n_len;
            r_fin.cks_nz   <= n_nz;
            r_fin.held     <= n_held;
            r_fin.sum      <= n_sum;
            r_fin.addr_sum <= n_addr_sum;
        end
    end

    assign o_fin_valid = r_fin_valid;
    assign o_fin       = r_fin;

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_xfer && i_last_byte |=> r_count == 16'd0 && r_sum == 32'd0 && !r_nz)
        else $error("datagram state not cleared after last byte");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_xfer && !i_last_byte && !i_first_byte && r_count != COUNT_MAX
        |=> r_count == $past(r_count) + 16'd1)
        else $error("byte count did not advance");

    a_snap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_valid && !i_fin_take |=> r_fin_valid && $stable(r_fin))
        else $error("pending snapshot lost or changed");

endmodule

// File: hw/rtl/udp_datagram_receive_checker.sv
// After the transfer of the last byte, the result passes through the snapshot register
// and then the output register.
// Throughput: one byte per cycle; the output register decouples a stalled consumer,
// and input stalls only when the snapshot stage and the output register are both full
// and the consumer is not ready.
// Reset: synchronous, active low; clears the slot ports, the datagram state and all
// valid flags, and sets the address sum to the UDP protocol number.
module udp_datagram_receive_checker import udpchk_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_first_byte,
    input  logic                  i_last_byte,
    input  logic [31:0]           i_source_addr,
    input  logic [31:0]           i_dest_addr,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [2:0]            o_verdict,
    output logic [1:0]            o_handler_slot,
    output logic [15:0]           o_sport_out,
    output logic [15:0]           o_dst_port_out,
    output logic [15:0]           o_data_len,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [15:0] r_slot_port [SLOT_REGS];

    logic        fin_valid;
    t_fin        fin;
    logic        take;
    logic        xfer;

    logic              r_out_valid;
    logic [2:0]        r_verdict;
    logic [SLOT_W-1:0] r_slot;
    logic [15:0]       r_sport;
    logic [15:0]       r_dst_port;
    logic [15:0]       r_data_len;

    logic [2:0]        n_verdict;
    logic [SLOT_W-1:0] n_slot;
    logic [15:0]       n_data_len;

    assign take       = fin_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !fin_valid || take;
    assign xfer       = i_in_valid && o_in_ready;

    udpchk_accum u_accum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_xfer        (xfer),
        .i_data_byte   (i_data_byte),
        .i_first_byte  (i_first_byte),
        .i_last_byte   (i_last_byte),
        .i_source_addr (i_source_addr),
        .i_dest_addr   (i_dest_addr),
        .i_fin_take    (take),
        .o_fin_valid   (fin_valid),
        .o_fin         (fin)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_REGS; i++) begin
                r_slot_port[i] <= '0;
            end
        end else if (i_cfg_we && i_cfg_index < CFG_IDX_W'(SLOT_REGS)) begin
            r_slot_port[i_cfg_index[SLOT_W-1:0]] <= i_cfg_data;
        end
    end

    logic [19:0] side_sum;
    logic [31:0] total;
    logic [16:0] fold1;
    logic [15:0] fold2;
    logic        cks_ok;
    logic        found;

    always_comb begin
        // pseudo-header, length and odd-byte pad
        side_sum = 20'(fin.addr_sum) + 20'(fin.hdr_len)
                 + (fin.hdr_len[0] ? {4'd0, fin.held, 8'd0} : 20'd0);
        total  = fin.sum + 32'(side_sum);
        fold1  = 17'(total[15:0]) + 17'(total[31:16]);
        fold2  = fold1[15:0] + 16'(fold1[16]);
        cks_ok = (fold2 == 16'd0) || (fold2 == CKSUM_ONES);

        found  = 1'b0;
        n_slot = '0;
        for (int i = 0; i < PORT_SLOTS; i++) begin
            if (!found && r_slot_port[i] != 16'd0 && r_slot_port[i] == fin.dst_port) begin
                found  = 1'b1;
                n_slot = SLOT_W'(i);
            end
        end

        if (fin.byte_len < MIN_UDP_LEN) begin
            n_verdict = VERDICT_SHORT;
        end else if (fin.hdr_len < MIN_UDP_LEN || fin.hdr_len > fin.byte_len) begin
            n_verdict = VERDICT_BAD_LEN;
        end else if (fin.cks_nz && !cks_ok) begin
            n_verdict = VERDICT_BAD_CKSUM;
        end else if (!found) begin
            n_verdict = VERDICT_NO_HANDLER;
        end else begin
            n_verdict = VERDICT_ACCEPT;
        end

        if (n_verdict == VERDICT_SHORT || n_verdict == VERDICT_BAD_LEN) begin
            n_data_len = 16'd0;
        end else begin
            n_data_len = fin.hdr_len - MIN_UDP_LEN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_verdict  <= n_verdict;
            r_slot     <= n_slot;
            r_sport    <= fin.sport;
            r_dst_port <= fin.dst_port;
            r_data_len <= n_data_len;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_verdict      = r_verdict;
    assign o_handler_slot = r_slot;
    assign o_sport_out    = r_sport;
    assign o_dst_port_out = r_dst_port;
    assign o_data_len     = r_data_len;

    a_accept_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_verdict == VERDICT_ACCEPT
        |-> r_slot_port[r_slot] == r_dst_port && r_dst_port != 16'd0)
        else $error("accepted datagram without matching slot");

    a_reject_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_verdict == VERDICT_SHORT || r_verdict == VERDICT_BAD_LEN)
        |-> r_data_len == 16'd0)
        else $error("payload length on length reject");

    a_verdict_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_verdict <= VERDICT_NO_HANDLER)
        else $error("verdict out of range");

endmodule
